/* rtl/core/mpe_pkg.sv */
// Shared types and constants for the midpoint ellipse generator.
// No dependencies; compile first.
package mpe_pkg;

  localparam int OUT_W  = 12;  // result coordinate width, two's complement
  localparam int DATA_W = 32;  // configuration data width
  localparam int ADDR_W = 4;   // byte address of four 32-bit registers

  // Reset values of the configuration registers
  localparam int RST_SEMI_X   = 100;
  localparam int RST_SEMI_Y   = 50;
  localparam int RST_CENTER_X = 320;
  localparam int RST_CENTER_Y = 240;

  typedef enum logic [1:0] {
    REG_SEMI_AXIS_X,
    REG_SEMI_AXIS_Y,
    REG_CENTER_X,
    REG_CENTER_Y
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_R1,
    PH_R2,
    PH_FIN
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_B,
    ST_LD_PY,
    ST_LD_DEC,
    ST_RC_BT,
    ST_RC_Y,
    ST_RC_AY,
    ST_RC_AB,
    ST_RC_END,
    ST_MOVE,
    ST_UPD,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_A,
    OP_LOAD_B,
    OP_LOAD_PY,
    OP_LOAD_DEC,
    OP_RC_T,
    OP_RC_BT,
    OP_RC_Y,
    OP_RC_AY,
    OP_RC_AB,
    OP_RC_END,
    OP_MOVE,
    OP_UPDATE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   region2;
  } dp_cmd_t;

  typedef struct packed {
    logic y_zero;  // y offset is zero
    logic r1_go;   // b^2*x < a^2*y: stay in region 1
  } dp_status_t;

  typedef struct packed {
    logic valid;
    logic point;
    logic last;
  } emit_t;

endpackage

/* rtl/core/mpe_in_if.sv */
// Request channel of the midpoint ellipse generator: restart or advance.
// Depends on nothing.
interface mpe_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

/* rtl/core/mpe_out_if.sv */
// Point channel of the midpoint ellipse generator: four symmetric coordinates.
// Depends on mpe_pkg.
interface mpe_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [mpe_pkg::OUT_W-1:0] x_right;
  logic signed [mpe_pkg::OUT_W-1:0] x_left;
  logic signed [mpe_pkg::OUT_W-1:0] y_top;
  logic signed [mpe_pkg::OUT_W-1:0] y_bottom;
  logic                            point_valid;
  logic                            last_point;

  modport source (output valid, output x_right, output x_left, output y_top,
                  output y_bottom, output point_valid, output last_point,
                  input ready);
  modport sink   (input valid, input x_right, input x_left, input y_top,
                  input y_bottom, input point_valid, input last_point,
                  output ready);
endinterface

/* rtl/core/midpoint_ellipse_generator.sv */
// Midpoint ellipse generator top level: configuration registers, output register, checks.
// A restart runs the load states LD_B, LD_PY and LD_DEC on the shared multiplier. A step
// runs MOVE and UPD, a region change step runs the RC states first, and an advance with
// no walk emits at once. A new request is taken only once the last result is registered.
// Reset (synchronous, rst_n low) restores the register defaults and stops the walk.
// Depends on mpe_pkg, mpe_in_if, mpe_out_if, mpe_ctrl and mpe_dp.
module midpoint_ellipse_generator #(
  parameter int COORD_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mpe_in_if.sink                        in_ch,
  mpe_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mpe_pkg::ADDR_W-1:0]    paddr,
  input  logic [mpe_pkg::DATA_W-1:0]    pwdata,
  output logic [mpe_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import mpe_pkg::*;

  // Sum width wide enough for centre plus offset before wrapping to OUT_W
  localparam int SUM_W = (COORD_BITS + 2 > OUT_W) ? COORD_BITS + 2 : OUT_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes land at the access phase; pready is tied
  // high, so no transaction is ever held in wait states.
  // ---------------------------------------------------------------------------
  logic [COORD_BITS-1:0] semi_x_r, semi_y_r, cen_x_r, cen_y_r;
  logic                  cfg_wr;
  reg_idx_t              cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      semi_x_r <= COORD_BITS'(RST_SEMI_X);
      semi_y_r <= COORD_BITS'(RST_SEMI_Y);
      cen_x_r  <= COORD_BITS'(RST_CENTER_X);
      cen_y_r  <= COORD_BITS'(RST_CENTER_Y);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SEMI_AXIS_X: semi_x_r <= pwdata[COORD_BITS-1:0];
        REG_SEMI_AXIS_Y: semi_y_r <= pwdata[COORD_BITS-1:0];
        REG_CENTER_X:    cen_x_r  <= pwdata[COORD_BITS-1:0];
        REG_CENTER_Y:    cen_y_r  <= pwdata[COORD_BITS-1:0];
        default:         semi_x_r <= semi_x_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SEMI_AXIS_X: prdata = DATA_W'(semi_x_r);
      REG_SEMI_AXIS_Y: prdata = DATA_W'(semi_y_r);
      REG_CENTER_X:    prdata = DATA_W'(cen_x_r);
      REG_CENTER_Y:    prdata = DATA_W'(cen_y_r);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Controller and datapath. The controller only moves past a result once the
  // output register can take it, so no result is ever dropped.
  // ---------------------------------------------------------------------------
  dp_cmd_t             cmd;
  dp_status_t          status;
  emit_t               emit;
  logic                out_free;
  logic [COORD_BITS:0] off_x, off_y;

  mpe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_restart (in_ch.restart),
    .in_ready   (in_ch.ready),
    .out_free   (out_free),
    .status     (status),
    .cmd        (cmd),
    .emit       (emit)
  );

  mpe_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk    (clk),
    .cfg_a  (semi_x_r),
    .cfg_b  (semi_y_r),
    .cmd    (cmd),
    .status (status),
    .off_x  (off_x),
    .off_y  (off_y)
  );

  // ---------------------------------------------------------------------------
  // Output register. Centre registers are read live when a result is formed;
  // sums wrap to the 12-bit two's complement result width.
  // ---------------------------------------------------------------------------
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] xr_r, xl_r, yt_r, yb_r;
  logic                    pv_r, lp_r;
  logic                    out_load;
  logic [SUM_W-1:0]        xr_sum, xl_sum, yt_sum, yb_sum;

  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = emit.valid && out_free;

  assign xr_sum = SUM_W'(cen_x_r) + SUM_W'(off_x);
  assign xl_sum = SUM_W'(cen_x_r) - SUM_W'(off_x);
  assign yt_sum = SUM_W'(cen_y_r) + SUM_W'(off_y);
  assign yb_sum = SUM_W'(cen_y_r) - SUM_W'(off_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Empty results carry all-zero coordinates
  always_ff @(posedge clk) begin
    if (out_load) begin
      xr_r <= emit.point ? $signed(xr_sum[OUT_W-1:0]) : '0;
      xl_r <= emit.point ? $signed(xl_sum[OUT_W-1:0]) : '0;
      yt_r <= emit.point ? $signed(yt_sum[OUT_W-1:0]) : '0;
      yb_r <= emit.point ? $signed(yb_sum[OUT_W-1:0]) : '0;
      pv_r <= emit.point;
      lp_r <= emit.last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.x_right     = xr_r;
  assign out_ch.x_left      = xl_r;
  assign out_ch.y_top       = yt_r;
  assign out_ch.y_bottom    = yb_r;
  assign out_ch.point_valid = pv_r;
  assign out_ch.last_point  = lp_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // The closing point of a quarter lies on the horizontal axis
  a_last_on_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_point |-> out_ch.point_valid && out_ch.y_top == out_ch.y_bottom)
    else $error("last point off the horizontal axis");

  // An empty result carries no coordinates and no end flag
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.point_valid |-> !out_ch.last_point && out_ch.x_right == 0 &&
      out_ch.x_left == 0 && out_ch.y_top == 0 && out_ch.y_bottom == 0)
    else $error("empty result carries data");

  // A restart runs the multiplier sequence, so the next transaction waits
  a_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.restart |=> !in_ch.ready)
    else $error("transaction taken during restart sequence");

endmodule

/* rtl/core/mpe_dp.sv */
// Datapath: offsets, incremental products, decision value and the shared multiplier.
// Depends on mpe_pkg; driven by mpe_ctrl.
module mpe_dp #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic [COORD_BITS-1:0] cfg_a,
  input  logic [COORD_BITS-1:0] cfg_b,
  input  mpe_pkg::dp_cmd_t      cmd,
  output mpe_pkg::dp_status_t   status,
  output logic [COORD_BITS:0]   off_x,
  output logic [COORD_BITS:0]   off_y
);
  import mpe_pkg::*;

  localparam int OFF_W  = COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int MB_W   = 2 * COORD_BITS + 4;
  localparam int PROD_W = SQ_W + MB_W;
  localparam int PX_W   = 3 * COORD_BITS + 1;
  localparam int DEC_W  = 4 * COORD_BITS + 8;

  logic [SQ_W-1:0]         a_sq_r, b_sq_r;
  logic [OFF_W-1:0]        x_r, y_r;
  logic [PX_W-1:0]         px_r, py_r;
  logic signed [DEC_W-1:0] dec_r;
  logic [PROD_W-1:0]       prod_r;

  logic [SQ_W-1:0]         a_sq_nxt, b_sq_nxt;
  logic [OFF_W-1:0]        x_nxt, y_nxt;
  logic [PX_W-1:0]         px_nxt, py_nxt;
  logic signed [DEC_W-1:0] dec_nxt;
  logic [PROD_W-1:0]       prod_nxt;

  logic [SQ_W-1:0]         mul_a;
  logic [MB_W-1:0]         mul_b;
  logic [COORD_BITS+1:0]   t_val;
  logic [OFF_W-1:0]        ym1;
  logic                    dec_neg, dec_pos, mov_x, mov_y;
  logic signed [DEC_W-1:0] aa4, bb4, px8, py8, prod_s, prod4, inc_k;

  assign t_val   = {x_r, 1'b1};
  assign ym1     = y_r - OFF_W'(1);
  assign dec_neg = dec_r < 0;
  assign dec_pos = dec_r > 0;
  assign mov_x   = cmd.region2 ? !dec_pos : 1'b1;
  assign mov_y   = cmd.region2 ? 1'b1 : !dec_neg;

  assign aa4    = $signed(DEC_W'(a_sq_r)) <<< 2;
  assign bb4    = $signed(DEC_W'(b_sq_r)) <<< 2;
  assign px8    = $signed(DEC_W'(px_r)) <<< 3;
  assign py8    = $signed(DEC_W'(py_r)) <<< 3;
  assign prod_s = $signed(DEC_W'(prod_r));
  assign prod4  = prod_s <<< 2;
  assign inc_k  = cmd.region2 ? (mov_x ? aa4 : -aa4) : bb4;

  // Shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_LOAD_A: begin
        mul_a = SQ_W'(cfg_a);
        mul_b = MB_W'(cfg_a);
      end
      OP_LOAD_B: begin
        mul_a = SQ_W'(cfg_b);
        mul_b = MB_W'(cfg_b);
      end
      OP_LOAD_PY: begin
        mul_a = a_sq_r;
        mul_b = MB_W'(y_r);
      end
      OP_RC_T: begin
        mul_a = SQ_W'(t_val);
        mul_b = MB_W'(t_val);
      end
      OP_RC_BT: begin
        mul_a = b_sq_r;
        mul_b = prod_r[MB_W-1:0];
      end
      OP_RC_Y: begin
        mul_a = SQ_W'(ym1);
        mul_b = MB_W'(ym1);
      end
      OP_RC_AY: begin
        mul_a = a_sq_r;
        mul_b = prod_r[MB_W-1:0];
      end
      OP_RC_AB: begin
        mul_a = a_sq_r;
        mul_b = MB_W'(b_sq_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    a_sq_nxt = a_sq_r;
    b_sq_nxt = b_sq_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    px_nxt   = px_r;
    py_nxt   = py_r;
    dec_nxt  = dec_r;
    case (cmd.op)
      OP_LOAD_A: begin
        x_nxt = '0;
        y_nxt = OFF_W'(cfg_b);
      end
      OP_LOAD_B:  a_sq_nxt = prod_r[SQ_W-1:0];
      OP_LOAD_PY: b_sq_nxt = prod_r[SQ_W-1:0];
      OP_LOAD_DEC: begin
        px_nxt  = '0;
        py_nxt  = prod_r[PX_W-1:0];
        dec_nxt = bb4 - prod4 + $signed(DEC_W'(a_sq_r));
      end
      OP_RC_Y:   dec_nxt = prod_s;
      OP_RC_AB:  dec_nxt = dec_r + prod4;
      OP_RC_END: dec_nxt = dec_r - prod4;
      OP_MOVE: begin
        if (mov_x) begin
          x_nxt  = x_r + OFF_W'(1);
          px_nxt = px_r + PX_W'(b_sq_r);
        end
        if (mov_y) begin
          y_nxt  = y_r - OFF_W'(1);
          py_nxt = py_r - PX_W'(a_sq_r);
        end
      end
      OP_UPDATE: begin
        // decision is still the pre-move value, so the move flags repeat
        dec_nxt = dec_r + (mov_x ? px8 : '0) - (mov_y ? py8 : '0) + inc_k;
      end
      default: dec_nxt = dec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    a_sq_r <= a_sq_nxt;
    b_sq_r <= b_sq_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    dec_r  <= dec_nxt;
    prod_r <= prod_nxt;
  end

  assign status.y_zero = (y_r == '0);
  assign status.r1_go  = (px_r < py_r);
  assign off_x         = x_r;
  assign off_y         = y_r;

endmodule

/* rtl/core/mpe_ctrl.sv */
// Controller: sequences restart, region change and raster steps, and issues results.
// Depends on mpe_pkg; commands mpe_dp.
module mpe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_restart,
  output logic                in_ready,
  input  logic                out_free,
  input  mpe_pkg::dp_status_t status,
  output mpe_pkg::dp_cmd_t    cmd,
  output mpe_pkg::emit_t      emit
);
  import mpe_pkg::*;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   pt_r, pt_nxt;
  logic   last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_IDLE;
      pt_r    <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      pt_r    <= pt_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    pt_nxt      = pt_r;
    last_nxt    = last_r;
    in_ready    = 1'b0;
    cmd.op      = OP_NONE;
    cmd.region2 = (phase_r == PH_R2);
    emit        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_restart) begin
            cmd.op    = OP_LOAD_A;
            state_nxt = ST_LD_B;
          end else if (phase_r == PH_R1 && status.r1_go) begin
            cmd.op    = OP_MOVE;
            state_nxt = ST_UPD;
          end else if (phase_r == PH_R1) begin
            cmd.op    = OP_RC_T;
            state_nxt = ST_RC_BT;
          end else if (phase_r == PH_R2) begin
            cmd.op    = OP_MOVE;
            state_nxt = ST_UPD;
          end else begin
            // no walk in progress: empty result
            emit.valid = 1'b1;
            pt_nxt     = 1'b0;
            last_nxt   = 1'b0;
            state_nxt  = out_free ? ST_IDLE : ST_EMIT;
          end
        end
      end
      ST_LD_B:  begin
        cmd.op    = OP_LOAD_B;
        state_nxt = ST_LD_PY;
      end
      ST_LD_PY: begin
        cmd.op    = OP_LOAD_PY;
        state_nxt = ST_LD_DEC;
      end
      ST_LD_DEC: begin
        cmd.op     = OP_LOAD_DEC;
        phase_nxt  = status.y_zero ? PH_FIN : PH_R1;
        emit.valid = 1'b1;
        emit.point = 1'b1;
        emit.last  = status.y_zero;
        pt_nxt     = 1'b1;
        last_nxt   = status.y_zero;
        state_nxt  = out_free ? ST_IDLE : ST_EMIT;
      end
      ST_RC_BT: begin
        cmd.op    = OP_RC_BT;
        state_nxt = ST_RC_Y;
      end
      ST_RC_Y: begin
        cmd.op    = OP_RC_Y;
        state_nxt = ST_RC_AY;
      end
      ST_RC_AY: begin
        cmd.op    = OP_RC_AY;
        state_nxt = ST_RC_AB;
      end
      ST_RC_AB: begin
        cmd.op    = OP_RC_AB;
        state_nxt = ST_RC_END;
      end
      ST_RC_END: begin
        cmd.op    = OP_RC_END;
        phase_nxt = PH_R2;
        state_nxt = ST_MOVE;
      end
      ST_MOVE: begin
        cmd.op    = OP_MOVE;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.op     = OP_UPDATE;
        phase_nxt  = status.y_zero ? PH_FIN : phase_r;
        emit.valid = 1'b1;
        emit.point = 1'b1;
        emit.last  = status.y_zero;
        pt_nxt     = 1'b1;
        last_nxt   = status.y_zero;
        state_nxt  = out_free ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        emit.valid = 1'b1;
        emit.point = pt_r;
        emit.last  = last_r;
        state_nxt  = out_free ? ST_IDLE : ST_EMIT;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* dv/mpe_tb_pkg.sv */
// Scoreboard for the midpoint ellipse generator testbench: point prediction and result checks.
// Depends on mpe_pkg for the register and phase enums and the reset defaults.
package mpe_tb_pkg;
  import mpe_pkg::*;

  localparam int COORD_BITS = 10;

  typedef struct packed {
    logic signed [OUT_W-1:0] x_right;
    logic signed [OUT_W-1:0] x_left;
    logic signed [OUT_W-1:0] y_top;
    logic signed [OUT_W-1:0] y_bottom;
    logic                    point_valid;
    logic                    last_point;
  } point_t;

  class point_scoreboard;
    // register copy
    logic [COORD_BITS-1:0] semi_x, semi_y, centre_x, centre_y;
    // walk state
    logic [10:0]        walk_x, walk_y;
    logic signed [47:0] decision;
    phase_t             walk_phase;
    logic [19:0]        a_sq, b_sq;

    point_t expected_points[$];
    int     error_count;

    function new();
      semi_x     = COORD_BITS'(RST_SEMI_X);
      semi_y     = COORD_BITS'(RST_SEMI_Y);
      centre_x   = COORD_BITS'(RST_CENTER_X);
      centre_y   = COORD_BITS'(RST_CENTER_Y);
      walk_x     = '0;
      walk_y     = '0;
      decision   = '0;
      walk_phase = PH_IDLE;
      a_sq       = '0;
      b_sq       = '0;
      error_count = 0;
    endfunction

    function void write_register(reg_idx_t idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_SEMI_AXIS_X: semi_x   = data[COORD_BITS-1:0];
        REG_SEMI_AXIS_Y: semi_y   = data[COORD_BITS-1:0];
        REG_CENTER_X:    centre_x = data[COORD_BITS-1:0];
        REG_CENTER_Y:    centre_y = data[COORD_BITS-1:0];
      endcase
    endfunction

    // Work out the point that one accepted request must produce.
    function void note_request(bit restart);
      point_t p;
      longint aa, bb, x, y, d, t;
      bit     stepped_r1;
      p = '0;
      stepped_r1 = 1'b0;
      if (restart) begin
        a_sq = 20'(semi_x) * 20'(semi_x);
        b_sq = 20'(semi_y) * 20'(semi_y);
        walk_x = '0;
        walk_y = 11'(semi_y);
      end
      aa = longint'(a_sq);
      bb = longint'(b_sq);
      x  = longint'(walk_x);
      y  = longint'(walk_y);
      d  = longint'(decision);
      if (restart) begin
        if (y == 0) begin
          d = 0;
          walk_phase = PH_FIN;
          p.last_point = 1'b1;
        end else begin
          d = 4 * bb - 4 * aa * y + aa;
          walk_phase = PH_R1;
        end
        p.point_valid = 1'b1;
      end else if (walk_phase == PH_R1 || walk_phase == PH_R2) begin
        if (walk_phase == PH_R1) begin
          if (bb * x < aa * y) begin
            stepped_r1 = 1'b1;
            x++;
            if (d < 0) begin
              d += 4 * (2 * bb * x + bb);
            end else begin
              y--;
              d += 4 * (2 * bb * x + bb - 2 * aa * y);
            end
          end else begin
            // region change: fresh decision at the midpoint below, then a region 2 step
            t = 2 * x + 1;
            d = bb * t * t + 4 * aa * (y - 1) * (y - 1) - 4 * aa * bb;
            walk_phase = PH_R2;
          end
        end
        if (!stepped_r1) begin
          if (d > 0) begin
            y--;
            d -= 4 * (2 * aa * y + aa);
          end else begin
            x++;
            y--;
            d += 4 * (2 * bb * x + aa - 2 * aa * y);
          end
        end
        if (y <= 0) begin
          y = 0;
          walk_phase = PH_FIN;
          p.last_point = 1'b1;
        end
        p.point_valid = 1'b1;
      end
      walk_x   = x[10:0];
      walk_y   = y[10:0];
      decision = d[47:0];
      if (p.point_valid) begin
        // centre registers are read live
        p.x_right  = OUT_W'(longint'(centre_x) + x);
        p.x_left   = OUT_W'(longint'(centre_x) - x);
        p.y_top    = OUT_W'(longint'(centre_y) + y);
        p.y_bottom = OUT_W'(longint'(centre_y) - y);
      end
      expected_points.push_back(p);
    endfunction

    function string show(point_t p);
      return $sformatf("xr=%0d xl=%0d yt=%0d yb=%0d valid=%0b last=%0b",
                       p.x_right, p.x_left, p.y_top, p.y_bottom,
                       p.point_valid, p.last_point);
    endfunction

    function void flag(string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        flag({"point with no request pending: ", show(got)});
        return;
      end
      want = expected_points.pop_front();
      if (got !== want) flag({"expected ", show(want), " got ", show(got)});
    endfunction

    function int outstanding();
      return expected_points.size();
    endfunction
  endclass

endpackage

/* dv/midpoint_ellipse_generator_tb.sv */
// Top-level testbench for the midpoint ellipse generator: drives requests and APB writes,
// checks every point against the scoreboard. Depends on mpe_pkg, mpe_in_if, mpe_out_if,
// mpe_tb_pkg and the block under test.
module midpoint_ellipse_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mpe_pkg::*;
  import mpe_tb_pkg::*;

  localparam int CYCLE_LIMIT     = 400_000;
  localparam int SETTLE_CYCLES   = 16;   // covers the longest step, the region change
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 125;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  mpe_in_if  in_ch ();
  mpe_out_if out_ch ();

  point_scoreboard sb;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int cycle_count;

  midpoint_ellipse_generator uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop: end the run if the block hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Receiver: stall the point channel at random according to the current phase.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Sample every accepted point at the rising edge and check it.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_point({out_ch.x_right, out_ch.x_left, out_ch.y_top, out_ch.y_bottom,
                      out_ch.point_valid, out_ch.last_point});
    end
  end

  // Present one request and hold it until the transaction completes. Valid is left high
  // so that the next request can follow back to back; a gap lowers it first.
  task automatic send_request(input bit restart);
    @(negedge clk);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(restart);
  endtask

  // Optionally restart, then advance a number of times.
  task automatic send_requests(input bit restart_first, input int advances);
    if (restart_first) send_request(1'b1);
    repeat (advances) send_request(1'b0);
  endtask

  // Drop valid, wait for every outstanding point, then let the datapath settle.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input reg_idx_t idx, input logic [COORD_BITS-1:0] value,
                           input bit noisy);
    logic [DATA_W-1:0] data;
    data = {22'(noisy ? $urandom : 0), value};
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reprogram all four registers once the block has gone quiet.
  task automatic configure(input int sx, input int sy, input int cx, input int cy,
                           input bit noisy);
    wait_idle();
    write_reg(REG_SEMI_AXIS_X, COORD_BITS'(sx), noisy);
    write_reg(REG_SEMI_AXIS_Y, COORD_BITS'(sy), noisy);
    write_reg(REG_CENTER_X,    COORD_BITS'(cx), noisy);
    write_reg(REG_CENTER_Y,    COORD_BITS'(cy), noisy);
  endtask

  initial begin
    int sx, sy, cx, cy, sent, n, pick, span;
    sb = new();
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.restart  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: advance before any walk, then a few points on the reset ellipse.
    send_requests(1'b0, 1);
    send_requests(1'b1, 3);
    // Move the centre mid-walk: the latched axes carry on, the new centre shows at once.
    configure(2, 2, 0, 0, 1'b0);
    send_requests(1'b0, 3);
    // Tiny ellipse: through the region change to the end, then past it.
    send_requests(1'b1, 5);
    // Zero horizontal semi-axis: straight down in region 2, then one advance after the end.
    configure(0, 3, 1023, 1023, 1'b0);
    send_requests(1'b1, 4);
    // Zero vertical semi-axis: the start point is also the last.
    configure(1023, 0, 1023, 1023, 1'b0);
    send_requests(1'b1, 1);
    // Largest axes with extreme centres, so coordinates go negative and past 1023.
    configure(1023, 1023, 1023, 0, 1'b0);
    send_requests(1'b1, 3);

    // Random: mostly whole walks, some cut short by a restart, a little stray advancing.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        2:       begin sx = 1023; sy = 1023; end
        5:       begin sx = 1;    sy = 1023; end
        6:       begin sx = 1023; sy = $urandom_range(0, 3); end
        default: begin sx = $urandom_range(0, 15); sy = $urandom_range(0, 15); end
      endcase
      cx = (ph == 3) ? 0 : (ph == 4) ? 1023 : $urandom_range(0, 1023);
      cy = (ph == 4) ? 0 : (ph == 3) ? 1023 : $urandom_range(0, 1023);
      configure(sx, sy, cx, cy, 1'b1);
      case (ph % 4)
        0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin sender_idle_pct = 49; recv_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin sender_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        span = sx + sy + 2;
        if (pick < 95) begin
          n = (pick < 80) ? span : $urandom_range(0, span);
          if (n > ITEMS_PER_PHASE - sent - 1) n = ITEMS_PER_PHASE - sent - 1;
          send_requests(1'b1, n);
          sent += n + 1;
        end else begin
          n = $urandom_range(1, 3);
          send_requests(1'b0, n);
          sent += n;
        end
      end
    end

    // Drain and deliver the verdict.
    wait_idle();
    if (sb.error_count == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
